// ===== rtl/cbsd_pkg.sv =====
// Package for the correlator bank symbol demodulator.
// Holds register indexes, field widths, the controller state type and the datapath command struct.
package cbsd_pkg;

    localparam int SampleW = 16;
    localparam int CorrW = 4;
    localparam int TapIdxW = 6;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 7;
    localparam int MagSteps = 6;

    localparam logic [CfgIdxW-1:0] REG_DECIMATION = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_NUM_CORR = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_TAPS = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_MAG,
        ST_CMP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic shift_in;
        logic tap_write;
        logic acc_clear;
        logic mac_en;
        logic mag_en;
        logic [2:0] mag_step;
        logic best_clear;
        logic cmp_en;
    } dp_cmd_t;

endpackage

// ===== rtl/cbsd_if.sv =====
// Valid/ready channel interfaces for the demodulator.
// Depends on cbsd_pkg for field widths.
interface cbsd_in_if import cbsd_pkg::*; ();
    logic valid;
    logic ready;
    logic operation;
    logic signed [SampleW-1:0] sample_i;
    logic signed [SampleW-1:0] sample_q;
    logic [CorrW-1:0] tap_correlator;
    logic [TapIdxW-1:0] tap_index;
    logic signed [SampleW-1:0] tap_i;
    logic signed [SampleW-1:0] tap_q;
    modport source (output valid, operation, sample_i, sample_q, tap_correlator,
                    tap_index, tap_i, tap_q, input ready);
    modport sink (input valid, operation, sample_i, sample_q, tap_correlator,
                  tap_index, tap_i, tap_q, output ready);
endinterface

interface cbsd_out_if import cbsd_pkg::*; ();
    logic valid;
    logic ready;
    logic [CorrW-1:0] symbol;
    modport source (output valid, symbol, input ready);
    modport sink (input valid, symbol, output ready);
endinterface

interface cbsd_cfg_if import cbsd_pkg::*; ();
    logic valid;
    logic ready;
    logic [CfgIdxW-1:0] index;
    logic [CfgDataW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/cbsd_datapath.sv =====
// Datapath: sample window, tap memory, complex MAC, squared magnitude and arg-max.
// Depends on cbsd_pkg; driven by cbsd_ctrl through dp_cmd_t.
module cbsd_datapath
    import cbsd_pkg::*;
#(
    parameter int MAX_CORRELATORS = 16,
    parameter int MAX_TAPS = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  dp_cmd_t cmd,
    input  logic signed [SampleW-1:0] sample_i,
    input  logic signed [SampleW-1:0] sample_q,
    input  logic [CorrW-1:0] tap_correlator,
    input  logic [TapIdxW-1:0] tap_index,
    input  logic signed [SampleW-1:0] tap_i,
    input  logic signed [SampleW-1:0] tap_q,
    input  logic [$clog2(MAX_CORRELATORS)-1:0] corr_sel,
    input  logic [$clog2(MAX_TAPS+1)-1:0] tap_sel,
    input  logic [$clog2(MAX_TAPS+1)-1:0] len,
    output logic [CorrW-1:0] best_symbol
);
    localparam int CW = $clog2(MAX_CORRELATORS);
    localparam int TW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int LW = $clog2(MAX_TAPS+1);
    localparam int DEPTH = MAX_CORRELATORS * MAX_TAPS;
    localparam int AW = $clog2(DEPTH);
    localparam int PW = 2*SampleW + 1;
    localparam int AccW = PW + LW;
    localparam int MagW = 2*AccW + 1;
    localparam int HalfW = (AccW + 1) / 2;

    logic [2*SampleW-1:0] win_mem [MAX_TAPS];
    logic [TW-1:0] wr_ptr_reg;
    logic [LW-1:0] fill_reg;
    logic signed [2*SampleW-1:0] mem [DEPTH];
    logic signed [2*SampleW-1:0] rd_reg;
    logic signed [SampleW-1:0] xi_reg, xq_reg;
    logic signed [AccW-1:0] acc_re_reg, acc_im_reg;
    logic [2*HalfW-1:0] abs_re_reg, abs_im_reg;
    logic [MagW-1:0] mag_reg, best_reg;
    logic [CW-1:0] cmp_c_reg;
    logic [CorrW-1:0] best_c_reg;
    logic [CW-1:0] cmp_c_next;
    logic [CorrW-1:0] best_c_next;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [LW-1:0] w_full;
    logic [LW:0] w_sum, w_wrap;
    logic [TW-1:0] w_sel;
    logic w_zero;
    logic signed [SampleW-1:0] ri, rq;
    logic signed [PW-1:0] p_re, p_im;
    logic [2*HalfW-1:0] sq_src;
    logic [HalfW-1:0] sq_lo, sq_hi, op_a, op_b;
    logic [2*HalfW-1:0] prod;
    logic [MagW-1:0] term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else if (cmd.shift_in)
        begin
            wr_ptr_reg <= (wr_ptr_reg == TW'(MAX_TAPS-1)) ? '0 : wr_ptr_reg + TW'(1);
            if (fill_reg < LW'(MAX_TAPS))
                fill_reg <= fill_reg + LW'(1);
        end
    end

    assign wr_addr = AW'(32'(tap_correlator) * MAX_TAPS + 32'(tap_index));
    assign rd_addr = AW'(32'(corr_sel) * MAX_TAPS + 32'(tap_sel));
    assign w_full = LW'(MAX_TAPS) - len + tap_sel;
    assign w_sum = (LW+1)'(wr_ptr_reg) + (LW+1)'(w_full);
    assign w_wrap = (w_sum >= (LW+1)'(MAX_TAPS)) ? w_sum - (LW+1)'(MAX_TAPS) : w_sum;
    assign w_sel = w_wrap[TW-1:0];
    assign w_zero = (w_full < LW'(MAX_TAPS) - fill_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.shift_in)
            win_mem[wr_ptr_reg] <= {sample_i, sample_q};
        if (w_zero)
        begin
            xi_reg <= '0;
            xq_reg <= '0;
        end
        else
        begin
            xi_reg <= win_mem[w_sel][2*SampleW-1:SampleW];
            xq_reg <= win_mem[w_sel][SampleW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tap_write)
            mem[wr_addr] <= {tap_i, tap_q};
        rd_reg <= mem[rd_addr];
    end

    assign ri = rd_reg[2*SampleW-1:SampleW];
    assign rq = rd_reg[SampleW-1:0];
    assign p_re = PW'(xi_reg * ri) + PW'(xq_reg * rq);
    assign p_im = PW'(xq_reg * ri) - PW'(xi_reg * rq);
    assign cmp_c_next = cmp_c_reg + CW'(1);
    assign best_c_next = (mag_reg > best_reg) ? CorrW'(cmp_c_reg) : best_c_reg;

    // The squared magnitude is built from half-width partial products, one a cycle.
    always_comb
    begin
        sq_src = (cmd.mag_step >= 3'd3) ? abs_im_reg : abs_re_reg;
        sq_lo = sq_src[HalfW-1:0];
        sq_hi = sq_src[2*HalfW-1:HalfW];
        case (cmd.mag_step)
            3'd0, 3'd3:
            begin
                op_a = sq_lo;
                op_b = sq_lo;
            end
            3'd1, 3'd4:
            begin
                op_a = sq_lo;
                op_b = sq_hi;
            end
            default:
            begin
                op_a = sq_hi;
                op_b = sq_hi;
            end
        endcase
        prod = op_a * op_b;
        case (cmd.mag_step)
            3'd0, 3'd3: term = MagW'(prod);
            3'd1, 3'd4: term = MagW'(prod) << (HalfW + 1);
            default:    term = MagW'(prod) << (2*HalfW);
        endcase
    end

    always_ff @(posedge clk)
    begin
        abs_re_reg <= (2*HalfW)'(acc_re_reg[AccW-1] ? -acc_re_reg : acc_re_reg);
        abs_im_reg <= (2*HalfW)'(acc_im_reg[AccW-1] ? -acc_im_reg : acc_im_reg);
        if (cmd.acc_clear)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (cmd.mac_en)
        begin
            acc_re_reg <= acc_re_reg + AccW'(p_re);
            acc_im_reg <= acc_im_reg + AccW'(p_im);
        end
        if (cmd.mag_en)
            mag_reg <= (cmd.mag_step == 3'd0) ? term : mag_reg + term;
        if (cmd.best_clear)
        begin
            best_reg <= '0;
            best_c_reg <= '0;
            cmp_c_reg <= '0;
        end
        else if (cmd.cmp_en)
        begin
            if (mag_reg > best_reg)
                best_reg <= mag_reg;
            best_c_reg <= best_c_next;
            cmp_c_reg <= cmp_c_next;
        end
    end

    assign best_symbol = best_c_reg;
endmodule

// ===== rtl/cbsd_ctrl.sv =====
// Controller: configuration registers, decimation phase and the decision sequencer.
// Depends on cbsd_pkg; drives cbsd_datapath through dp_cmd_t.
module cbsd_ctrl
    import cbsd_pkg::*;
#(
    parameter int MAX_CORRELATORS = 16,
    parameter int MAX_TAPS = 64,
    parameter int MAX_DECIMATION = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_op,
    input  logic [CorrW-1:0] tap_correlator,
    input  logic [TapIdxW-1:0] tap_index,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  logic cfg_valid,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output logic cfg_ready,
    output dp_cmd_t cmd,
    output logic [$clog2(MAX_CORRELATORS)-1:0] corr_sel,
    output logic [$clog2(MAX_TAPS+1)-1:0] tap_sel,
    output logic [$clog2(MAX_TAPS+1)-1:0] len
);
    localparam int CW = $clog2(MAX_CORRELATORS);
    localparam int LW = $clog2(MAX_TAPS+1);
    localparam int PhW = $clog2(MAX_DECIMATION+1);

    state_t state_reg, state_next;
    logic [CfgDataW-1:0] dec_cfg_reg, ncorr_cfg_reg, taps_cfg_reg;
    logic [PhW-1:0] phase_reg, phase_next, phase_inc, dec;
    logic [CW-1:0] corr_reg, corr_next;
    logic [LW-1:0] tap_reg, tap_next;
    logic [CW:0] ncorr;
    logic [1:0] drain_reg, drain_next;
    logic [2:0] step_reg, step_next;
    logic in_fire, sample_fire, load_fire, last_tap, last_corr;

    assign cfg_ready = 1'b1;
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire = in_valid && in_ready;
    assign sample_fire = in_fire && (in_op == OP_SAMPLE);
    assign load_fire = in_fire && (in_op == OP_LOAD)
                       && (32'(tap_correlator) < MAX_CORRELATORS)
                       && (32'(tap_index) < MAX_TAPS);

    always_comb
    begin
        if (dec_cfg_reg == '0)
            dec = PhW'(1);
        else if (32'(dec_cfg_reg) > MAX_DECIMATION)
            dec = PhW'(MAX_DECIMATION);
        else
            dec = PhW'(dec_cfg_reg);
        if (ncorr_cfg_reg == '0)
            ncorr = (CW+1)'(1);
        else if (32'(ncorr_cfg_reg) > MAX_CORRELATORS)
            ncorr = (CW+1)'(MAX_CORRELATORS);
        else
            ncorr = (CW+1)'(ncorr_cfg_reg);
        if (taps_cfg_reg == '0)
            len = LW'(1);
        else if (32'(taps_cfg_reg) > MAX_TAPS)
            len = LW'(MAX_TAPS);
        else
            len = LW'(taps_cfg_reg);
    end

    assign phase_inc = phase_reg + PhW'(1);
    assign phase_next = (phase_inc >= dec) ? '0 : phase_inc;
    assign last_tap = (tap_reg == len - LW'(1));
    assign last_corr = ((CW+1)'(corr_reg) == ncorr - (CW+1)'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dec_cfg_reg <= CfgDataW'(1);
            ncorr_cfg_reg <= CfgDataW'(2);
            taps_cfg_reg <= CfgDataW'(64);
            phase_reg <= '0;
            corr_reg <= '0;
            tap_reg <= '0;
            drain_reg <= '0;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            corr_reg <= corr_next;
            tap_reg <= tap_next;
            drain_reg <= drain_next;
            step_reg <= step_next;
            if (sample_fire)
                phase_reg <= phase_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_DECIMATION: dec_cfg_reg <= cfg_data;
                    REG_NUM_CORR:   ncorr_cfg_reg <= CfgDataW'(cfg_data[4:0]);
                    REG_TAPS:       taps_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        corr_next = corr_reg;
        tap_next = tap_reg;
        drain_next = drain_reg;
        step_next = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                corr_next = '0;
                tap_next = '0;
                if (sample_fire && phase_reg == '0)
                    state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (last_tap)
                begin
                    state_next = ST_DRAIN;
                    drain_next = 2'd0;
                end
                else
                    tap_next = tap_reg + LW'(1);
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 2'd1;
                step_next = '0;
                if (drain_reg == 2'd1)
                    state_next = ST_MAG;
            end
            ST_MAG:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'(MagSteps - 1))
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                tap_next = '0;
                if (last_corr)
                    state_next = ST_OUT;
                else
                begin
                    corr_next = corr_reg + CW'(1);
                    state_next = ST_MAC;
                end
            end
            ST_OUT:
                if (out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.shift_in = sample_fire;
        cmd.tap_write = load_fire;
        cmd.mag_step = step_reg;
        corr_sel = corr_reg;
        tap_sel = tap_reg;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.acc_clear = 1'b1;
                cmd.best_clear = 1'b1;
            end
            ST_MAC:
                cmd.mac_en = (tap_reg >= LW'(1));
            ST_DRAIN:
                cmd.mac_en = (drain_reg == 2'd0);
            ST_MAG:
                cmd.mag_en = 1'b1;
            ST_CMP:
            begin
                cmd.cmp_en = 1'b1;
                cmd.acc_clear = 1'b1;
            end
            ST_OUT:
                out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

// ===== rtl/correlator_bank_symbol_demod_top.sv =====
// Top level of the correlator bank symbol demodulator.
// Depends on cbsd_pkg, cbsd_if, cbsd_ctrl and cbsd_datapath.
//
// Channel  Direction  Carries
// in       sink       operation, sample and tap fields
// out      source     symbol
// cfg      sink       register index and data
//
// A tap load or a non-decision sample is taken only while idle. A decision sample is
// worked through by the single complex MAC, which walks the tap memory one tap a
// cycle for each correlator in use, and by the squared magnitude that follows it.
// The symbol is held until taken and input is stalled meanwhile. Reset empties the
// window and clears the phase and state; the configuration registers return to
// their defaults and the tap memory is not cleared.
module correlator_bank_symbol_demod_top
    import cbsd_pkg::*;
#(
    parameter int MAX_CORRELATORS = 16,
    parameter int MAX_TAPS = 64,
    parameter int MAX_DECIMATION = 64
)
(
    input logic clk,
    input logic rst_n,
    cbsd_in_if.sink in,
    cbsd_out_if.source out,
    cbsd_cfg_if.sink cfg
);
    localparam int CW = $clog2(MAX_CORRELATORS);
    localparam int LW = $clog2(MAX_TAPS+1);

    dp_cmd_t cmd;
    logic [CW-1:0] corr_sel;
    logic [LW-1:0] tap_sel, len;

    cbsd_ctrl #(
        .MAX_CORRELATORS(MAX_CORRELATORS),
        .MAX_TAPS(MAX_TAPS),
        .MAX_DECIMATION(MAX_DECIMATION)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in.valid),
        .in_op(in.operation),
        .tap_correlator(in.tap_correlator),
        .tap_index(in.tap_index),
        .in_ready(in.ready),
        .out_valid(out.valid),
        .out_ready(out.ready),
        .cfg_valid(cfg.valid),
        .cfg_index(cfg.index),
        .cfg_data(cfg.data),
        .cfg_ready(cfg.ready),
        .cmd(cmd),
        .corr_sel(corr_sel),
        .tap_sel(tap_sel),
        .len(len)
    );

    cbsd_datapath #(
        .MAX_CORRELATORS(MAX_CORRELATORS),
        .MAX_TAPS(MAX_TAPS)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .sample_i(in.sample_i),
        .sample_q(in.sample_q),
        .tap_correlator(in.tap_correlator),
        .tap_index(in.tap_index),
        .tap_i(in.tap_i),
        .tap_q(in.tap_q),
        .corr_sel(corr_sel),
        .tap_sel(tap_sel),
        .len(len),
        .best_symbol(out.symbol)
    );
endmodule
